FILE: rtl/core/shp_pkg.sv
package shp_pkg;

  localparam int KeyBytes = 32;
  localparam int KeyBits = 8 * KeyBytes;
  localparam int KeyIdxW = $clog2(KeyBytes);
  localparam int ShareHeadBytes = 4;
  localparam int FixedBytes = 34;
  localparam int HdrBytes = 3;

  localparam logic [7:0] MsgTypeSh = 8'd2;
  localparam logic [15:0] KeyShareExt = 16'd51;
  localparam logic [15:0] SuiteReset = 16'h1303;
  localparam logic [15:0] GroupReset = 16'h001d;

  localparam int QueueDepth = 2;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  typedef enum logic [0:0] {
    CFG_SUITE = 1'b0,
    CFG_GROUP = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_WRONG_TYPE = 4'd1,
    ST_TRUNCATED  = 4'd2,
    ST_BAD_SUITE  = 4'd3,
    ST_NO_EXT     = 4'd4,
    ST_OVERFLOW   = 4'd5,
    ST_EXT_LEN    = 4'd6,
    ST_SHORT      = 4'd7,
    ST_NOT_GROUP  = 4'd8,
    ST_NO_SHARE   = 4'd9
  } status_t;

  typedef enum logic [12:0] {
    PH_TYPE     = 13'b0000000000001,
    PH_HDR      = 13'b0000000000010,
    PH_FIXED    = 13'b0000000000100,
    PH_SIDLEN   = 13'b0000000001000,
    PH_SID      = 13'b0000000010000,
    PH_SUITE    = 13'b0000000100000,
    PH_COMP     = 13'b0000001000000,
    PH_EXTLEN   = 13'b0000010000000,
    PH_EXT_HEAD = 13'b0000100000000,
    PH_EXT_BODY = 13'b0001000000000,
    PH_EXT_IDLE = 13'b0010000000000,
    PH_TRAIL    = 13'b0100000000000,
    PH_ERR      = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    status_t             status;
    logic [KeyBits-1:0]  key;
  } job_t;

endpackage

FILE: rtl/core/shp_front.sv
module shp_front import shp_pkg::*; #(
  parameter int MAX_MESSAGE = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        queue_full,
  output logic        push,
  output job_t        job
);

  localparam int CntW = $clog2(MAX_MESSAGE + 1);

  logic [15:0] expected_suite;
  logic [15:0] expected_group;

  phase_t      phase, phase_next;
  logic [15:0] field_count, field_count_next;
  logic [7:0]  session_len, session_len_next;
  logic [15:0] suite_seen, suite_seen_next;
  logic [15:0] ext_block_left, ext_block_left_next;
  logic [15:0] ext_kind, ext_kind_next;
  logic [15:0] ext_body_left, ext_body_left_next;
  logic [31:0] share_header, share_header_next;
  logic        key_valid, key_valid_next;
  status_t     early_error, early_error_next;
  status_t     ext_error, ext_error_next;
  logic [CntW-1:0] msg_bytes;

  logic [7:0]  key_store [KeyBytes];
  logic        key_we;
  logic [KeyIdxW-1:0] key_idx;
  logic        accept;
  logic        in_body;
  logic [16:0] fc_inc;
  status_t     status_now;
  logic [KeyBits-1:0] key_now;

  assign byte_stall = queue_full;
  assign accept = byte_valid && !queue_full;
  assign push = accept && final_byte;
  assign fc_inc = {1'b0, field_count} + 17'd1;

  always_comb begin
    phase_next = phase;
    field_count_next = field_count;
    session_len_next = session_len;
    suite_seen_next = suite_seen;
    ext_block_left_next = ext_block_left;
    ext_kind_next = ext_kind;
    ext_body_left_next = ext_body_left;
    share_header_next = share_header;
    key_valid_next = key_valid;
    early_error_next = early_error;
    ext_error_next = ext_error;
    key_we = 1'b0;
    key_idx = field_count[KeyIdxW-1:0] - KeyIdxW'(ShareHeadBytes);
    in_body = 1'b1;
    if (msg_bytes < CntW'(MAX_MESSAGE)) begin
      case (phase)
        PH_TYPE: begin
          if (data_byte != MsgTypeSh) begin
            early_error_next = ST_WRONG_TYPE;
            phase_next = PH_ERR;
          end else begin
            phase_next = PH_HDR;
            field_count_next = '0;
          end
        end
        PH_HDR: begin
          if (field_count == 16'(HdrBytes - 1)) begin
            field_count_next = '0;
            phase_next = PH_FIXED;
          end else begin
            field_count_next = fc_inc[15:0];
          end
        end
        PH_FIXED: begin
          if (field_count == 16'(FixedBytes - 1)) begin
            field_count_next = '0;
            phase_next = PH_SIDLEN;
          end else begin
            field_count_next = fc_inc[15:0];
          end
        end
        PH_SIDLEN: begin
          session_len_next = data_byte;
          phase_next = (data_byte == 8'd0) ? PH_SUITE : PH_SID;
        end
        PH_SID: begin
          session_len_next = session_len - 8'd1;
          if (session_len == 8'd1) phase_next = PH_SUITE;
        end
        PH_SUITE: begin
          suite_seen_next = {suite_seen[7:0], data_byte};
          if (field_count == 16'd1) begin
            field_count_next = '0;
            phase_next = PH_COMP;
          end else begin
            field_count_next = fc_inc[15:0];
          end
        end
        PH_COMP: begin
          if (suite_seen != expected_suite) begin
            early_error_next = ST_BAD_SUITE;
            phase_next = PH_ERR;
          end else begin
            phase_next = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          ext_block_left_next = {ext_block_left[7:0], data_byte};
          if (field_count == 16'd1) begin
            field_count_next = '0;
            phase_next = (ext_block_left_next == 16'd0) ? PH_TRAIL : PH_EXT_HEAD;
          end else begin
            field_count_next = fc_inc[15:0];
          end
        end
        PH_EXT_HEAD, PH_EXT_BODY, PH_EXT_IDLE: begin
          if (ext_block_left == 16'd0) begin
            phase_next = PH_TRAIL;
          end else begin
            if (phase == PH_EXT_HEAD) begin
              if (field_count == 16'd0 && ext_block_left < 16'd4) begin
                phase_next = PH_EXT_IDLE;
              end else begin
                if (field_count < 16'd2) ext_kind_next = {ext_kind[7:0], data_byte};
                else ext_body_left_next = {ext_body_left[7:0], data_byte};
                if (field_count == 16'd3) begin
                  field_count_next = '0;
                  if (ext_body_left_next >= ext_block_left) begin
                    ext_error_next = ST_EXT_LEN;
                    phase_next = PH_EXT_IDLE;
                  end else if (ext_kind == KeyShareExt &&
                               ext_body_left_next < 16'(ShareHeadBytes)) begin
                    ext_error_next = ST_SHORT;
                    phase_next = PH_EXT_IDLE;
                  end else if (ext_body_left_next != 16'd0) begin
                    phase_next = PH_EXT_BODY;
                  end
                end else begin
                  field_count_next = fc_inc[15:0];
                end
              end
            end else if (phase == PH_EXT_BODY) begin
              if (ext_kind == KeyShareExt) begin
                if (field_count < 16'(ShareHeadBytes)) begin
                  share_header_next = {share_header[23:0], data_byte};
                  if (field_count == 16'(ShareHeadBytes - 1)) begin
                    if (share_header_next[31:16] != expected_group ||
                        share_header_next[15:0] != 16'(KeyBytes) ||
                        ext_body_left < 16'(ShareHeadBytes + KeyBytes)) begin
                      ext_error_next = ST_NOT_GROUP;
                      phase_next = PH_EXT_IDLE;
                      in_body = 1'b0;
                    end else begin
                      key_valid_next = 1'b1;
                    end
                  end
                end else if (field_count < 16'(ShareHeadBytes + KeyBytes)) begin
                  key_we = 1'b1;
                end
              end
              if (in_body) begin
                if (fc_inc >= {1'b0, ext_body_left}) begin
                  field_count_next = '0;
                  phase_next = PH_EXT_HEAD;
                end else begin
                  field_count_next = fc_inc[15:0];
                end
              end
            end
            ext_block_left_next = ext_block_left - 16'd1;
            if (ext_block_left == 16'd1) phase_next = PH_TRAIL;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (early_error_next != ST_OK) begin
      status_now = early_error_next;
    end else begin
      case (phase_next)
        PH_TYPE, PH_HDR: status_now = ST_WRONG_TYPE;
        PH_FIXED, PH_SIDLEN, PH_SID, PH_SUITE, PH_COMP: status_now = ST_TRUNCATED;
        PH_EXTLEN: status_now = ST_NO_EXT;
        PH_EXT_HEAD, PH_EXT_BODY, PH_EXT_IDLE: status_now = ST_OVERFLOW;
        default: begin
          if (ext_error_next != ST_OK) status_now = ext_error_next;
          else status_now = key_valid_next ? ST_OK : ST_NO_SHARE;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < KeyBytes; i++) begin
      key_now[KeyBits-1-8*i -: 8] =
        (key_we && key_idx == KeyIdxW'(i)) ? data_byte : key_store[i];
    end
  end

  assign job.status = status_now;
  assign job.key = key_now;

  always_ff @(posedge clk) begin
    if (accept && key_we) begin
      key_store[key_idx] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_suite <= SuiteReset;
      expected_group <= GroupReset;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SUITE: expected_suite <= cfg_data;
        CFG_GROUP: expected_group <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase <= PH_TYPE;
      field_count <= '0;
      session_len <= '0;
      suite_seen <= '0;
      ext_block_left <= '0;
      ext_kind <= '0;
      ext_body_left <= '0;
      share_header <= '0;
      key_valid <= 1'b0;
      early_error <= ST_OK;
      ext_error <= ST_OK;
      msg_bytes <= '0;
    end else if (accept) begin
      phase <= phase_next;
      field_count <= field_count_next;
      session_len <= session_len_next;
      suite_seen <= suite_seen_next;
      ext_block_left <= ext_block_left_next;
      ext_kind <= ext_kind_next;
      ext_body_left <= ext_body_left_next;
      share_header <= share_header_next;
      key_valid <= key_valid_next;
      early_error <= early_error_next;
      ext_error <= ext_error_next;
      if (msg_bytes < CntW'(MAX_MESSAGE)) msg_bytes <= msg_bytes + CntW'(1);
    end
  end

endmodule

FILE: rtl/core/shp_queue.sv
module shp_queue import shp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t             slots [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == QCntW'(QueueDepth));
  assign empty = (count == '0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + QPtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10: count <= count + QCntW'(1);
        2'b01: count <= count - QCntW'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/shp_back.sv
module shp_back import shp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  job_t        head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  status,
  output logic [63:0] key_word,
  output logic [1:0]  word_index,
  output logic        run_end
);

  logic [1:0]  word_sel;
  logic        load;
  logic        last;
  logic [63:0] word_now;

  assign load = !empty && (!result_valid || !result_stall);
  assign last = (head.status != ST_OK) || (word_sel == 2'd3);
  assign pop = load && last;

  always_comb begin
    case (word_sel)
      2'd0: word_now = head.key[255:192];
      2'd1: word_now = head.key[191:128];
      2'd2: word_now = head.key[127:64];
      2'd3: word_now = head.key[63:0];
      default: word_now = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= head.status;
      key_word <= (head.status == ST_OK) ? word_now : 64'd0;
      word_index <= (head.status == ST_OK) ? word_sel : 2'd0;
      run_end <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      word_sel <= '0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        word_sel <= last ? 2'd0 : word_sel + 2'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/server_hello_parser.sv
// ServerHello parser: takes one message byte per cycle on the byte channel unless
// byte_stall is high and, on the byte flagged final, gives either one error word or four
// key words (status 0, word_index 0..3, key bytes big-endian, run_end on the last).
// Results pass through the result queue and the output register, then leave one word per
// cycle unless result_stall holds them. A two-entry result queue sits between parser and
// output, so byte_stall rises only while two finished messages still wait to be emitted.
// Bytes beyond MAX_MESSAGE are taken but not parsed. The user writes expected_suite and
// expected_group through cfg_write while the block is idle; the block does not enforce it.
module server_hello_parser import shp_pkg::*; #(
  parameter int MAX_MESSAGE = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  input  logic        byte_valid,
  output logic        byte_stall,
  output logic [3:0]  status,
  output logic [63:0] key_word,
  output logic [1:0]  word_index,
  output logic        run_end,
  output logic        result_valid,
  input  logic        result_stall
);

  logic push;
  job_t push_job;
  logic pop;
  logic full;
  logic empty;
  job_t head;

  shp_front #(
    .MAX_MESSAGE(MAX_MESSAGE)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .data_byte(data_byte),
    .final_byte(final_byte),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .queue_full(full),
    .push(push),
    .job(push_job)
  );

  shp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .pop(pop),
    .full(full),
    .empty(empty),
    .head(head)
  );

  shp_back u_back (
    .clk(clk),
    .rst(rst),
    .empty(empty),
    .head(head),
    .pop(pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .key_word(key_word),
    .word_index(word_index),
    .run_end(run_end)
  );

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> run_end && word_index == 2'd0 && key_word == 64'd0)
    else $error("error word not a single cleared word");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_OK |-> run_end == (word_index == 2'd3))
    else $error("run_end out of step with word_index");

  a_final_queued: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && final_byte |=> !empty || result_valid)
    else $error("final word lost");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && status == ST_OK && !run_end |=>
      result_valid && status == ST_OK && word_index == $past(word_index) + 2'd1)
    else $error("key words out of order");

endmodule
